// File: design/lslc_pkg.sv
// Shared widths, codes and segment tables for the lux calculation pipeline.
`default_nettype none
package lslc_pkg;

    localparam int CNT_W       = 16;                        // raw count width
    localparam int BASE_W      = 15;                        // integration scale width
    localparam int GAIN_SHIFT  = 4;                         // high gain (low_gain clear) multiplies by 16
    localparam int SCALE_W     = BASE_W + GAIN_SHIFT;
    localparam int PS_W        = CNT_W + SCALE_W;           // count times scale
    localparam int CHAN_SHIFT  = 10;
    localparam int C_W         = PS_W - CHAN_SHIFT;         // scaled channel width
    localparam int Q_W         = 12;                        // saturated quotient width
    localparam int SAT_SH      = Q_W - CHAN_SHIFT;
    localparam int DIV_STEPS   = 2;                         // quotient bits per stage
    localparam int DIV_STAGES  = Q_W / DIV_STEPS;
    localparam int KNEE_W      = 10;
    localparam int COEF_W      = 10;
    localparam int SEG_IDX_W   = 3;
    localparam int SEG_KNEES   = 7;
    localparam int PROD_W      = C_W + COEF_W;
    localparam int LUX_SHIFT   = 14;
    localparam int LUX_W       = 20;
    localparam int SH_W        = PROD_W + 1 - LUX_SHIFT;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SDATA_W     = 32;
    localparam int MDATA_W     = 24;

    localparam logic [BASE_W-1:0] SCALE_13MS  = 15'h7517;
    localparam logic [BASE_W-1:0] SCALE_101MS = 15'h0FE7;
    localparam logic [BASE_W-1:0] SCALE_NONE  = 15'h0400;

    localparam logic [1:0] INT_13MS  = 2'd0;
    localparam logic [1:0] INT_101MS = 2'd1;

    localparam logic PKG_T  = 1'b0;
    localparam logic PKG_CS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PKG_TYPE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT = 2'd3;

    localparam logic [CNT_W-1:0] SAT_LIMIT_RESET = 16'd4900;
    localparam logic [PROD_W:0]  ROUND_HALF      = (PROD_W+1)'(1) << (LUX_SHIFT - 1);
    localparam logic [LUX_W-1:0] LUX_MAX         = '1;

    typedef struct packed {
        logic             low_gain;
        logic [1:0]       integration_mode;
        logic             package_type;
        logic [CNT_W-1:0] saturation_limit;
    } lslc_cfg_t;

    typedef struct packed {
        logic [C_W-1:0] c0;
        logic [C_W-1:0] c1;
        logic           ok;
    } lslc_scaled_t;

    typedef struct packed {
        logic [C_W-1:0] c0;
        logic [C_W-1:0] c1;
        logic [C_W-1:0] rem;
        logic [Q_W-1:0] quo;
        logic           sat;
        logic           ok;
    } lslc_div_t;

    typedef struct packed {
        logic [C_W-1:0]    c0;
        logic [C_W-1:0]    c1;
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
        logic              ok;
    } lslc_coef_t;

    typedef struct packed {
        logic [PROD_W-1:0] pos;
        logic [PROD_W-1:0] neg;
        logic              ok;
    } lslc_prod_t;

    // Upper ratio bound of each segment; the last segment is open-ended.
    function automatic logic [KNEE_W-1:0] seg_knee(input logic pkg,
                                                   input logic [SEG_IDX_W-1:0] idx);
        case (idx)
            3'd0:    seg_knee = (pkg == PKG_CS) ? 10'h043 : 10'h040;
            3'd1:    seg_knee = (pkg == PKG_CS) ? 10'h085 : 10'h080;
            3'd2:    seg_knee = (pkg == PKG_CS) ? 10'h0C8 : 10'h0C0;
            3'd3:    seg_knee = (pkg == PKG_CS) ? 10'h10A : 10'h100;
            3'd4:    seg_knee = (pkg == PKG_CS) ? 10'h14D : 10'h138;
            3'd5:    seg_knee = 10'h19A;
            3'd6:    seg_knee = 10'h29A;
            default: seg_knee = '1;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] seg_b(input logic pkg,
                                                input logic [SEG_IDX_W-1:0] idx);
        case (idx)
            3'd0:    seg_b = (pkg == PKG_CS) ? 10'h204 : 10'h1F2;
            3'd1:    seg_b = (pkg == PKG_CS) ? 10'h228 : 10'h214;
            3'd2:    seg_b = (pkg == PKG_CS) ? 10'h253 : 10'h23F;
            3'd3:    seg_b = (pkg == PKG_CS) ? 10'h282 : 10'h270;
            3'd4:    seg_b = (pkg == PKG_CS) ? 10'h177 : 10'h16F;
            3'd5:    seg_b = (pkg == PKG_CS) ? 10'h101 : 10'h0D2;
            3'd6:    seg_b = (pkg == PKG_CS) ? 10'h037 : 10'h018;
            default: seg_b = '0;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] seg_m(input logic pkg,
                                                input logic [SEG_IDX_W-1:0] idx);
        case (idx)
            3'd0:    seg_m = (pkg == PKG_CS) ? 10'h1AD : 10'h1BE;
            3'd1:    seg_m = (pkg == PKG_CS) ? 10'h2C1 : 10'h2D1;
            3'd2:    seg_m = (pkg == PKG_CS) ? 10'h363 : 10'h37B;
            3'd3:    seg_m = (pkg == PKG_CS) ? 10'h3DF : 10'h3FE;
            3'd4:    seg_m = (pkg == PKG_CS) ? 10'h1DD : 10'h1FC;
            3'd5:    seg_m = (pkg == PKG_CS) ? 10'h127 : 10'h0FB;
            3'd6:    seg_m = (pkg == PKG_CS) ? 10'h02B : 10'h012;
            default: seg_m = '0;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: design/lslc_scale.sv
// Input stage: channel scaling by integration time and gain, validity check.
`default_nettype none
module lslc_scale (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  lslc_pkg::lslc_cfg_t           cfg,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire [lslc_pkg::CNT_W-1:0]     bb,
    input  wire [lslc_pkg::CNT_W-1:0]     ir,
    output logic                          out_valid,
    input  wire                           out_ready,
    output lslc_pkg::lslc_scaled_t        out_data
);
    import lslc_pkg::*;

    logic [BASE_W-1:0]  base;
    logic [SCALE_W-1:0] scale;
    logic [PS_W-1:0]    p0;
    logic [PS_W-1:0]    p1;
    lslc_scaled_t       data_next;
    lslc_scaled_t       data_reg;
    logic               valid_reg;

    always_comb begin
        case (cfg.integration_mode)
            INT_13MS:  base = SCALE_13MS;
            INT_101MS: base = SCALE_101MS;
            default:   base = SCALE_NONE;
        endcase
        scale = cfg.low_gain ? SCALE_W'(base) : (SCALE_W'(base) << GAIN_SHIFT);
        p0 = PS_W'(bb) * PS_W'(scale);
        p1 = PS_W'(ir) * PS_W'(scale);
        data_next.c0 = p0[PS_W-1:CHAN_SHIFT];
        data_next.c1 = p1[PS_W-1:CHAN_SHIFT];
        // bb / ir < 2 is the same as bb < 2 * ir for nonzero ir
        data_next.ok = !((ir != '0) && ({1'b0, bb} < {ir, 1'b0})
                         && (bb > cfg.saturation_limit));
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// File: design/lslc_div.sv
// Pipelined restoring divider for the IR/broadband ratio, saturated quotient.
`default_nettype none
module lslc_div (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      in_valid,
    output logic                     in_ready,
    input  lslc_pkg::lslc_scaled_t   in_data,
    output logic                     out_valid,
    input  wire                      out_ready,
    output lslc_pkg::lslc_div_t      out_data
);
    import lslc_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] stg_valid;
    logic [DIV_STAGES-1:0] rdy;
    lslc_div_t             stg_in   [DIV_STAGES];
    lslc_div_t             div_next [DIV_STAGES];
    lslc_div_t             div_reg  [DIV_STAGES];

    // Numerator is c1 << CHAN_SHIFT; its top bits seed the remainder and
    // quotient overflow (c1 >= c0 << SAT_SH) is caught up front.
    always_comb begin
        stg_in[0].c0  = in_data.c0;
        stg_in[0].c1  = in_data.c1;
        stg_in[0].ok  = in_data.ok;
        stg_in[0].rem = C_W'(in_data.c1 >> SAT_SH);
        stg_in[0].quo = '0;
        stg_in[0].sat = ({{SAT_SH{1'b0}}, in_data.c1} >= {in_data.c0, {SAT_SH{1'b0}}});
    end
    assign stg_valid[0] = in_valid;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            if (s > 0) begin : g_link
                assign stg_in[s]    = div_reg[s-1];
                assign stg_valid[s] = valid_reg[s-1];
            end

            if (s == DIV_STAGES - 1) begin : g_last
                assign rdy[s] = !valid_reg[s] || out_ready;
            end else begin : g_mid
                assign rdy[s] = !valid_reg[s] || rdy[s+1];
            end

            always_comb begin
                lslc_div_t      w;
                logic [Q_W-1:0] nlow;
                logic [C_W:0]   t;
                w    = stg_in[s];
                nlow = {w.c1[SAT_SH-1:0], {CHAN_SHIFT{1'b0}}};
                for (int j = 0; j < DIV_STEPS; j++) begin
                    t = {w.rem, nlow[Q_W-1-(s*DIV_STEPS+j)]};
                    if (t >= {1'b0, w.c0}) begin
                        w.rem = C_W'(t - {1'b0, w.c0});
                        w.quo = {w.quo[Q_W-2:0], 1'b1};
                    end else begin
                        w.rem = t[C_W-1:0];
                        w.quo = {w.quo[Q_W-2:0], 1'b0};
                    end
                end
                div_next[s] = w;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (rdy[s]) begin
                    valid_reg[s] <= stg_valid[s];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[s] && stg_valid[s]) begin
                    div_reg[s] <= div_next[s];
                end
            end
        end
    endgenerate

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = div_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: design/lslc_mul.sv
// Segment lookup from the rounded ratio, then the two coefficient products.
`default_nettype none
module lslc_mul (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    package_type,
    input  wire                    in_valid,
    output logic                   in_ready,
    input  lslc_pkg::lslc_div_t    in_data,
    output logic                   out_valid,
    input  wire                    out_ready,
    output lslc_pkg::lslc_prod_t   out_data
);
    import lslc_pkg::*;

    logic [Q_W-1:0]       q;
    logic [Q_W:0]         q_inc;
    logic [Q_W-1:0]       ratio;
    logic [SEG_IDX_W-1:0] idx;
    lslc_coef_t           coef_next;
    lslc_coef_t           coef_reg;
    logic                 coef_valid_reg;
    logic                 coef_ready;
    lslc_prod_t           prod_next;
    lslc_prod_t           prod_reg;
    logic                 prod_valid_reg;
    logic                 prod_ready;

    // Stage A: round the ratio, pick the first segment whose knee bounds it
    always_comb begin
        q     = in_data.sat ? '1 : in_data.quo;
        q_inc = {1'b0, q} + (Q_W+1)'(1);
        ratio = (in_data.c0 == '0) ? '0 : q_inc[Q_W:1];
        idx   = SEG_IDX_W'(SEG_KNEES);
        for (int i = SEG_KNEES - 1; i >= 0; i--) begin
            if (ratio <= Q_W'(seg_knee(package_type, SEG_IDX_W'(i)))) begin
                idx = SEG_IDX_W'(i);
            end
        end
        coef_next.c0 = in_data.c0;
        coef_next.c1 = in_data.c1;
        coef_next.b  = seg_b(package_type, idx);
        coef_next.m  = seg_m(package_type, idx);
        coef_next.ok = in_data.ok;
    end

    // Stage B: b * ch0 and m * ch1
    always_comb begin
        prod_next.pos = PROD_W'(coef_reg.c0) * PROD_W'(coef_reg.b);
        prod_next.neg = PROD_W'(coef_reg.c1) * PROD_W'(coef_reg.m);
        prod_next.ok  = coef_reg.ok;
    end

    assign prod_ready = !prod_valid_reg || out_ready;
    assign coef_ready = !coef_valid_reg || prod_ready;
    assign in_ready   = coef_ready;
    assign out_valid  = prod_valid_reg;
    assign out_data   = prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (coef_ready) begin
                coef_valid_reg <= in_valid;
            end
            if (prod_ready) begin
                prod_valid_reg <= coef_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (coef_ready && in_valid) begin
            coef_reg <= coef_next;
        end
        if (prod_ready && coef_valid_reg) begin
            prod_reg <= prod_next;
        end
    end

endmodule
`default_nettype wire

// File: design/lslc_fin.sv
// Output stage: clamped difference, rounding shift and 20-bit saturation.
`default_nettype none
module lslc_fin (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  lslc_pkg::lslc_prod_t         in_data,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [lslc_pkg::LUX_W-1:0]   lux,
    output logic                         ok
);
    import lslc_pkg::*;

    logic [PROD_W-1:0] diff;
    logic [PROD_W:0]   rnd;
    logic [SH_W-1:0]   sh;
    logic [LUX_W-1:0]  lux_next;
    logic [LUX_W-1:0]  lux_reg;
    logic              ok_reg;
    logic              valid_reg;

    always_comb begin
        diff     = (in_data.pos > in_data.neg) ? (in_data.pos - in_data.neg) : '0;
        rnd      = {1'b0, diff} + ROUND_HALF;
        sh       = rnd[PROD_W:LUX_SHIFT];
        lux_next = (|sh[SH_W-1:LUX_W]) ? LUX_MAX : sh[LUX_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign lux       = lux_reg;
    assign ok        = ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lux_reg <= lux_next;
            ok_reg  <= in_data.ok;
        end
    end

endmodule
`default_nettype wire

// File: design/light_sensor_lux_calculation_top.sv
// Top level of the photodiode lux calculation pipeline.
//
// Usage:
//   - Input channel (s_*): one word per reading, broadband count in
//     s_tdata[15:0] and infrared count in s_tdata[31:16].
//   - Result channel (m_*): lux in m_tdata[19:0] (upper bits zero) and the
//     reading-valid flag in m_tuser[0]; one result word per input word.
//   - Configuration: cfg_we writes cfg_data into register cfg_index
//     (0 low_gain, 1 integration_mode, 2 package_type, 3 saturation_limit).
//     Write only while no reading is in flight.
//   - From input acceptance to m_tvalid a word passes one scaling
//     stage, six divider stages (two quotient bits each), segment lookup,
//     coefficient multiply and the round/saturate output register.
//   - Throughput is one word per cycle while m_tready stays high; every
//     stage is registered and each stage refills as soon as its word moves on.
//   - Reset (aresetn low, synchronous) drops all words in flight and loads
//     the register defaults (0, 0, 0, 4900).
//   - When m_tready is low, the output word holds and the stages behind it
//     keep filling until each holds a word; then s_tready drops. Nothing is
//     lost or repeated.
`default_nettype none
module light_sensor_lux_calculation_top (
    input  wire                                aclk,
    input  wire                                aresetn,
    // configuration write port
    input  wire                                cfg_we,
    input  wire [lslc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [lslc_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input words
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire [lslc_pkg::SDATA_W-1:0]        s_tdata,   // [15:0] broadband_count, [31:16] infrared_count
    // result words
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [lslc_pkg::MDATA_W-1:0]       m_tdata,   // [19:0] lux_value, [23:20] zero
    output logic [0:0]                         m_tuser    // [0] reading_valid
);
    import lslc_pkg::*;

    lslc_cfg_t    cfg_reg;
    lslc_scaled_t scl_data;
    logic         scl_valid;
    logic         scl_ready;
    lslc_div_t    div_data;
    logic         div_valid;
    logic         div_ready;
    lslc_prod_t   prod_data;
    logic         prod_valid;
    logic         prod_ready;
    logic [LUX_W-1:0] lux;
    logic         ok;

    // Configuration registers: masked to width, no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_gain         <= 1'b0;
            cfg_reg.integration_mode <= INT_13MS;
            cfg_reg.package_type     <= PKG_T;
            cfg_reg.saturation_limit <= SAT_LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOW_GAIN:  cfg_reg.low_gain         <= cfg_data[0];
                CFG_INT_MODE:  cfg_reg.integration_mode <= cfg_data[1:0];
                CFG_PKG_TYPE:  cfg_reg.package_type     <= cfg_data[0];
                CFG_SAT_LIMIT: cfg_reg.saturation_limit <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Scale both channels and check the raw counts for saturation
    lslc_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .bb        (s_tdata[CNT_W-1:0]),
        .ir        (s_tdata[2*CNT_W-1:CNT_W]),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    // IR/broadband ratio, saturated quotient
    lslc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_data   (scl_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    // Segment pick and the two products
    lslc_mul u_mul (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .package_type (cfg_reg.package_type),
        .in_valid     (div_valid),
        .in_ready     (div_ready),
        .in_data      (div_data),
        .out_valid    (prod_valid),
        .out_ready    (prod_ready),
        .out_data     (prod_data)
    );

    // Clamp, round, shift, saturate; holds the result word
    lslc_fin u_fin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .lux       (lux),
        .ok        (ok)
    );

    assign m_tdata = MDATA_W'(lux);
    assign m_tuser = ok;

endmodule
`default_nettype wire

// File: design/lslc_chk.sv
// Port-level checker for the lux calculation top level, bound to it.
`default_nettype none
module lslc_chk (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tvalid,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [lslc_pkg::MDATA_W-1:0]        m_tdata,
    input wire [0:0]                          m_tuser
);
    import lslc_pkg::*;

    // A stalled result word holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Reset drops every word in flight
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // An empty output register lets the whole pipeline accept
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A taking receiver never backs up the input side
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while receiver ready");

endmodule

bind light_sensor_lux_calculation_top lslc_chk u_lslc_chk (.*);
`default_nettype wire

// File: tb/tb_light_sensor_lux_calculation_top.sv
// Self-checking testbench for the photodiode lux calculation pipeline top level.
`default_nettype none
module tb_light_sensor_lux_calculation_top;
    import lslc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int MAX_IDLE       = 13;
    localparam int HOLD_CYCLES    = 120;    // long receiver hold-off to back up the pipe
    localparam int DRAIN_CYCLES   = 20;     // pipe is 10 deep
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_WORDS    = 192;
    localparam int NUM_ROWS       = 18;
    localparam int MAX_PRINTS     = 40;

    // integration modes the package leaves unnamed
    localparam logic [1:0] INT_402MS = 2'd2;
    localparam logic [1:0] INT_SPARE = 2'd3;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic             valid;
    } lux_word_t;

    typedef struct {
        lslc_cfg_t        cfg;
        logic [CNT_W-1:0] bb;
        logic [CNT_W-1:0] ir;
        bit               typed;
        lux_word_t        want;
    } lux_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SDATA_W-1:0]    s_tdata   = '0;   // [15:0] broadband_count, [31:16] infrared_count
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [MDATA_W-1:0]    m_tdata;          // [19:0] lux_value, [23:20] zero
    logic [0:0]            m_tuser;          // [0] reading_valid

    // Register shadow used for prediction; starts at the reset defaults.
    lslc_cfg_t  cur_cfg = {1'b0, INT_13MS, PKG_T, SAT_LIMIT_RESET};
    lux_word_t  expected_lux_q[$];
    int         error_count  = 0;
    int         words_seen   = 0;
    int         stall_cycles = 0;
    bit         tx_idle_on   = 1'b1;
    bit         rx_idle_on   = 1'b1;
    bit         hold_req     = 1'b0;

    light_sensor_lux_calculation_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Segment table entry packed as {knee, b, m}; the last segment is open-ended
    // and carries zero coefficients in both packages.
    function automatic logic [35:0] segment_entry(input logic cs, input int idx);
        case (idx)
            0:       segment_entry = cs ? {12'h043, 12'h204, 12'h1AD}
                                        : {12'h040, 12'h1F2, 12'h1BE};
            1:       segment_entry = cs ? {12'h085, 12'h228, 12'h2C1}
                                        : {12'h080, 12'h214, 12'h2D1};
            2:       segment_entry = cs ? {12'h0C8, 12'h253, 12'h363}
                                        : {12'h0C0, 12'h23F, 12'h37B};
            3:       segment_entry = cs ? {12'h10A, 12'h282, 12'h3DF}
                                        : {12'h100, 12'h270, 12'h3FE};
            4:       segment_entry = cs ? {12'h14D, 12'h177, 12'h1DD}
                                        : {12'h138, 12'h16F, 12'h1FC};
            5:       segment_entry = cs ? {12'h19A, 12'h101, 12'h127}
                                        : {12'h19A, 12'h0D2, 12'h0FB};
            6:       segment_entry = cs ? {12'h29A, 12'h037, 12'h02B}
                                        : {12'h29A, 12'h018, 12'h012};
            default: segment_entry = {12'hFFF, 12'h000, 12'h000};
        endcase
    endfunction

    // Lux and validity for one reading under the given register settings.
    function automatic lux_word_t predict_lux(input lslc_cfg_t c,
                                              input logic [CNT_W-1:0] bb,
                                              input logic [CNT_W-1:0] ir);
        logic [63:0] scale, c0, c1, ratio, pos, neg, lux;
        logic [35:0] seg;
        int          i;
        lux_word_t   r;
        case (c.integration_mode)
            INT_13MS:  scale = 64'h7517;
            INT_101MS: scale = 64'h0FE7;
            default:   scale = 64'h0400;   // 402 ms and the spare mode: unity
        endcase
        if (!c.low_gain) begin
            scale = scale << 4;
        end
        c0 = (64'(bb) * scale) >> 10;
        c1 = (64'(ir) * scale) >> 10;
        // zero broadband gives ratio zero
        ratio = (c0 != 0) ? (c1 << 10) / c0 : 64'd0;
        ratio = (ratio + 64'd1) >> 1;
        i   = 0;
        seg = segment_entry(c.package_type, 0);
        while (i < 7 && ratio > 64'(seg[35:24])) begin
            i++;
            seg = segment_entry(c.package_type, i);
        end
        pos = c0 * 64'(seg[23:12]);
        neg = c1 * 64'(seg[11:0]);
        lux = (pos > neg) ? pos - neg : 64'd0;
        lux = (lux + 64'd8192) >> 14;
        r.lux   = (lux > 64'hFFFFF) ? 20'hFFFFF : lux[19:0];
        r.valid = !(ir != 0 && (bb / ir) < 2 && bb > c.saturation_limit);
        return r;
    endfunction

    function automatic lux_row_t make_row(input logic lg, input logic [1:0] mode,
                                          input logic pkg, input logic [15:0] limit,
                                          input logic [15:0] bb, input logic [15:0] ir,
                                          input bit typed, input logic [19:0] lux,
                                          input logic valid);
        lux_row_t r;
        r.cfg   = {lg, mode, pkg, limit};
        r.bb    = bb;
        r.ir    = ir;
        r.typed = typed;
        r.want  = {lux, valid};
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        error_count++;
        if (error_count <= MAX_PRINTS) begin
            $display("ERROR word %0d: %s expected %0d got %0d", words_seen, field, want, got);
        end
    endtask

    // Drop valid, wait for the pipe to empty, then write all four registers.
    task automatic apply_config(input lslc_cfg_t c);
        s_tvalid <= 1'b0;
        while (expected_lux_q.size() != 0) @(posedge aclk);
        // junk in the unused upper data bits must be masked by the block
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LOW_GAIN;
        cfg_data  <= {15'($urandom), c.low_gain};
        @(posedge aclk);
        cfg_index <= CFG_INT_MODE;
        cfg_data  <= {14'($urandom), c.integration_mode};
        @(posedge aclk);
        cfg_index <= CFG_PKG_TYPE;
        cfg_data  <= {15'($urandom), c.package_type};
        @(posedge aclk);
        cfg_index <= CFG_SAT_LIMIT;
        cfg_data  <= c.saturation_limit;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        cur_cfg = c;
    endtask

    // Offer one reading, hold it until accepted, then queue its expected result.
    task automatic send_word(input logic [CNT_W-1:0] bb, input logic [CNT_W-1:0] ir,
                             input bit typed, input lux_word_t want);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ir, bb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_lux_q.push_back(typed ? want : predict_lux(cur_cfg, bb, ir));
    endtask

    // Random reading, with draws that sweep the segments, the saturation check and extremes.
    task automatic draw_reading(output logic [CNT_W-1:0] bb, output logic [CNT_W-1:0] ir);
        int unsigned a, b;
        case ($urandom_range(0, 5))
            0: begin
                a = $urandom_range(0, 65535);
                b = $urandom_range(0, 65535);
            end
            1: begin
                // sweep the ratio over every segment, past the top knee
                a = $urandom_range(0, 65535);
                b = a * $urandom_range(0, 1400) / 1000;
            end
            2: begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            3: begin
                // straddle the saturation limit with bb/ir near two
                a = cur_cfg.saturation_limit + $urandom_range(0, 2);
                a = (a == 0) ? 0 : a - 1;
                if (a > 65535) begin
                    a = 65535;
                end
                b = (a >> 1) + $urandom_range(0, 1);
            end
            4: begin
                a = $urandom_range(0, 1) ? $urandom_range(0, 1) : 65534 + $urandom_range(0, 1);
                b = $urandom_range(0, 1) ? $urandom_range(0, 1) : 65534 + $urandom_range(0, 1);
            end
            default: begin
                a = $urandom_range(0, 65535);
                b = 0;
                if ($urandom_range(0, 1)) begin
                    b = a;
                    a = 0;
                end
            end
        endcase
        if (b > 65535) begin
            b = 65535;
        end
        bb = a[15:0];
        ir = b[15:0];
    endtask

    // Result side: idle per word, honor a long hold-off when asked, check each word.
    initial begin : result_sink
        int        gap;
        lux_word_t want;
        wait (aresetn === 1'b1);
        forever begin
            gap = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            if (hold_req) begin
                hold_req = 1'b0;
                gap      = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            words_seen++;
            if (expected_lux_q.size() == 0) begin
                report_mismatch("unexpected word, tdata", 0, m_tdata);
            end else begin
                want = expected_lux_q.pop_front();
                if (m_tdata[LUX_W-1:0] !== want.lux) begin
                    report_mismatch("lux_value", want.lux, m_tdata[LUX_W-1:0]);
                end
                if (m_tdata[MDATA_W-1:LUX_W] !== '0) begin
                    report_mismatch("tdata pad", 0, m_tdata[MDATA_W-1:LUX_W]);
                end
                if (m_tuser[0] !== want.valid) begin
                    report_mismatch("reading_valid", want.valid, m_tuser[0]);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL light_sensor_lux_calculation_top");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        lux_row_t         rows [NUM_ROWS];
        lslc_cfg_t        c;
        logic [CNT_W-1:0] bb, ir;
        lux_word_t        no_want;

        no_want = '0;
        // Directed table. The first rows run on the reset defaults, untouched.
        // zero counts, then zero broadband with full infrared: negative difference clamps
        rows[0]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'd0, 16'd0, 1, 20'd0, 1);
        rows[1]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'd0, 16'hFFFF, 1, 20'd0, 1);
        rows[2]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'hFFFF, 16'd0, 0, 0, 0);
        // full scale both channels: flagged invalid, lux still carried
        rows[3]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'hFFFF, 16'hFFFF, 0, 0, 0);
        // edges of the bb/ir < 2 and bb > limit checks
        rows[4]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'd9800, 16'd4900, 0, 0, 0);
        rows[5]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'd9799, 16'd4900, 0, 0, 0);
        rows[6]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'd4900, 16'd4900, 0, 0, 0);
        rows[7]  = make_row(0, INT_13MS, PKG_T, SAT_LIMIT_RESET, 16'd4901, 16'd4900, 0, 0, 0);
        rows[8]  = make_row(1, INT_101MS, PKG_T, 16'd4900, 16'hFFFF, 16'd0, 0, 0, 0);
        rows[9]  = make_row(1, INT_101MS, PKG_T, 16'd4900, 16'd1000, 16'd300, 0, 0, 0);
        rows[10] = make_row(1, INT_101MS, PKG_T, 16'd4900, 16'd32768, 16'd21845, 0, 0, 0);
        // CS package above its last knee gives zero lux
        rows[11] = make_row(1, INT_402MS, PKG_CS, 16'd4900, 16'd1, 16'hFFFF, 1, 20'd0, 1);
        rows[12] = make_row(1, INT_402MS, PKG_CS, 16'd4900, 16'd40000, 16'd32000, 0, 0, 0);
        rows[13] = make_row(1, INT_402MS, PKG_CS, 16'd4900, 16'd30000, 16'd39000, 0, 0, 0);
        // spare integration mode behaves as unity scale; zero limit flags almost anything
        rows[14] = make_row(0, INT_SPARE, PKG_CS, 16'd0, 16'd1, 16'd1, 0, 0, 0);
        rows[15] = make_row(0, INT_SPARE, PKG_CS, 16'd0, 16'hFFFF, 16'd0, 0, 0, 0);
        rows[16] = make_row(0, INT_SPARE, PKG_CS, 16'd0, 16'd0, 16'd0, 1, 20'd0, 1);
        rows[17] = make_row(0, INT_13MS, PKG_T, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        for (int k = 0; k < NUM_ROWS; k++) begin
            if (rows[k].cfg != cur_cfg) begin
                apply_config(rows[k].cfg);
            end
            send_word(rows[k].bb, rows[k].ir, rows[k].typed, rows[k].want);
        end

        // Random phases: sweep the registers, the extremes first, and vary idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 4) begin
                c.low_gain         = 1'(p >> 1);
                c.integration_mode = 2'(p);
                c.package_type     = 1'(p);
                case (p)
                    0:       c.saturation_limit = 16'd0;
                    1:       c.saturation_limit = 16'hFFFF;
                    2:       c.saturation_limit = SAT_LIMIT_RESET;
                    default: c.saturation_limit = 16'($urandom);
                endcase
            end else begin
                c = lslc_cfg_t'(20'($urandom));
            end
            // phase kinds: both idle, sender flat out with a long hold-off, none, sender only
            tx_idle_on = (p % 4 == 0) || (p % 4 == 3);
            rx_idle_on = (p % 4 == 0) || (p % 4 == 1);
            apply_config(c);
            hold_req = (p % 4 == 1);
            repeat (PHASE_WORDS) begin
                draw_reading(bb, ir);
                send_word(bb, ir, 1'b0, no_want);
            end
        end

        s_tvalid <= 1'b0;
        while (expected_lux_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("PASS light_sensor_lux_calculation_top");
        end else begin
            $display("FAIL light_sensor_lux_calculation_top");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
design/lslc_pkg.sv
design/lslc_scale.sv
design/lslc_div.sv
design/lslc_mul.sv
design/lslc_fin.sv
design/light_sensor_lux_calculation_top.sv
design/lslc_chk.sv
tb/tb_light_sensor_lux_calculation_top.sv
